FILE: hw/rtl/smaa_pkg.sv
// ----------------------------------------------------------------------------
// smaa_pkg
// Shared types and constants for the sensor moving-average alarm block.
// ----------------------------------------------------------------------------
package smaa_pkg;

  localparam int FILL_W  = 4;
  localparam int HEAD_W  = 3;
  localparam int SUM_W   = 20;
  localparam int DIV_STEPS = SUM_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 88;

  localparam logic [2:0] ST_NORMAL     = 3'd0;
  localparam logic [2:0] ST_HOT        = 3'd1;
  localparam logic [2:0] ST_COLD       = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_REGISTERED = 3'd4;
  localparam logic [2:0] ST_DUPLICATE  = 3'd5;
  localparam logic [2:0] ST_FULL       = 3'd6;

  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_MEASURE  = 1'b1;

  localparam logic CFG_HIGH_LIMIT = 1'b0;
  localparam logic CFG_LOW_LIMIT  = 1'b1;

  typedef struct packed {
    logic [15:0]        id;
    logic [15:0]        room;
    logic [FILL_W-1:0]  fill;
    logic [HEAD_W-1:0]  head;
    logic signed [15:0] mean;
    logic [31:0]        stamp;
  } ent_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic sum;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic is_meas;
    logic sum_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/smaa_ctrl.sv
// ----------------------------------------------------------------------------
// smaa_ctrl
// Sequencer that steps one word through lookup, then for a measurement of a
// known sensor window update, sum and divide, and then result hand-off.
// ----------------------------------------------------------------------------
module smaa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  smaa_pkg::sts_t sts,
  output smaa_pkg::cmd_t cmd
);
  import smaa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_SUM    = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = (sts.is_meas && sts.hit) ? S_UPDATE : S_OUT;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/smaa_dp.sv
// ----------------------------------------------------------------------------
// smaa_dp
// Datapath: sensor table, sample windows, accumulator, serial divider,
// limit registers and the output register.
// ----------------------------------------------------------------------------
module smaa_dp #(
  parameter int WINDOW      = 5,
  parameter int MAX_SENSORS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  smaa_pkg::cmd_t                   cmd,
  output smaa_pkg::sts_t                   sts,
  input  logic [smaa_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                             in_kind,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [smaa_pkg::OUT_DATA_W-1:0]  out_data
);
  import smaa_pkg::*;

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W = $clog2(MAX_SENSORS + 1) > 0 ? $clog2(MAX_SENSORS + 1) : 1;
  localparam int WA_W  = (MAX_SENSORS * WINDOW > 1) ? $clog2(MAX_SENSORS * WINDOW) : 1;
  localparam int WD    = MAX_SENSORS * WINDOW;
  localparam logic [WA_W-1:0]   WIN_C  = WA_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  USED_MAX = CNT_W'(MAX_SENSORS);
  localparam int DC_W = $clog2(DIV_STEPS + 1);

  ent_t               ent_mem [MAX_SENSORS];
  logic signed [15:0] win_mem [WD];

  logic               kind_q;
  logic [15:0]        id_q, room_q;
  logic signed [15:0] val_q;
  logic [31:0]        time_q;
  logic signed [15:0] high_limit, low_limit;
  logic [CNT_W-1:0]   used;

  logic [CNT_W-1:0]   scan_addr;
  logic               rd_pend, scan_done, hit;
  logic [IDX_W-1:0]   rd_idx, slot;
  ent_t               rec_q;
  logic               ent_rd_en, match;

  logic [WA_W-1:0]    base_q;
  logic [FILL_W-1:0]  fill_q, sum_cnt;
  logic [HEAD_W-1:0]  head_q;
  logic               win_pend, sum_done, win_rd_en;
  logic signed [15:0] win_q;
  logic signed [SUM_W-1:0] acc;

  logic [SUM_W-1:0]   quo;
  logic [3:0]         rem;
  logic               neg;
  logic [DC_W-1:0]    div_cnt;
  logic [4:0]         trial;
  logic [SUM_W-1:0]   mean_full;
  logic signed [15:0] mean;

  logic [WA_W-1:0]    slot_base;
  logic [FILL_W-1:0]  fill_new;
  logic [HEAD_W-1:0]  head_new;
  logic [2:0]         res_status;
  logic [15:0]        res_room;
  logic signed [15:0] res_mean;
  logic [31:0]        res_time;
  logic [FILL_W-1:0]  res_held;
  logic               ent_we;
  logic [IDX_W-1:0]   ent_wa;
  ent_t               ent_wd;

  assign match     = rd_pend && (rec_q.id == id_q);
  assign ent_rd_en = cmd.scan && !scan_done && !match && (scan_addr < used);
  assign win_rd_en = cmd.sum && !sum_done && (sum_cnt < fill_q);
  assign slot_base = WA_W'(WA_W'(slot) * WIN_C);
  assign fill_new  = (rec_q.fill < FILL_MAX) ? rec_q.fill + 1'b1 : rec_q.fill;
  assign head_new  = (rec_q.head == HEAD_LAST) ? '0 : rec_q.head + 1'b1;
  assign trial     = {rem, quo[SUM_W-1]};
  assign mean_full = neg ? (~quo + 1'b1) : quo;
  assign mean      = mean_full[15:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      id_q   <= in_data[15:0];
      room_q <= in_data[31:16];
      val_q  <= in_data[47:32];
      time_q <= in_data[79:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit <= 16'sd5120;
      low_limit  <= 16'sd2560;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_LIMIT: high_limit <= cfg_data;
        CFG_LOW_LIMIT:  low_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table search: one read issued per cycle, compared against the id in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.load) begin
      scan_done <= 1'b0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      scan_addr <= '0;
    end else if (cmd.scan && !scan_done) begin
      rd_pend <= ent_rd_en;
      if (match) begin
        hit       <= 1'b1;
        slot      <= rd_idx;
        scan_done <= 1'b1;
      end else if (!ent_rd_en && !rd_pend) begin
        scan_done <= 1'b1;
      end
      if (ent_rd_en) begin
        rd_idx    <= scan_addr[IDX_W-1:0];
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      rec_q <= ent_mem[scan_addr[IDX_W-1:0]];
    end
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      win_mem[WA_W'(slot_base + WA_W'(rec_q.head))] <= val_q;
    end
    if (win_rd_en) begin
      win_q <= win_mem[WA_W'(base_q + WA_W'(sum_cnt))];
    end
  end

  // Window sum over the held samples.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_done <= 1'b0;
      win_pend <= 1'b0;
    end else if (cmd.update) begin
      base_q   <= slot_base;
      fill_q   <= fill_new;
      head_q   <= head_new;
      sum_cnt  <= '0;
      acc      <= '0;
      sum_done <= 1'b0;
      win_pend <= 1'b0;
    end else if (cmd.sum && !sum_done) begin
      win_pend <= win_rd_en;
      if (win_pend) begin
        acc <= acc + SUM_W'(win_q);
      end
      if (win_rd_en) begin
        sum_cnt <= sum_cnt + 1'b1;
      end else if (!win_pend) begin
        sum_done <= 1'b1;
      end
    end
  end

  // Restoring divider of the magnitude, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      neg     <= acc[SUM_W-1];
      quo     <= acc[SUM_W-1] ? (~acc + 1'b1) : acc;
      rem     <= '0;
      div_cnt <= DC_W'(DIV_STEPS);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
      if (trial >= {1'b0, fill_q}) begin
        rem <= 4'(trial - {1'b0, fill_q});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[3:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    res_status = ST_NORMAL;
    res_room   = '0;
    res_mean   = '0;
    res_time   = '0;
    res_held   = '0;
    ent_we     = 1'b0;
    ent_wa     = slot;
    ent_wd     = rec_q;
    if (kind_q == KIND_MEASURE) begin
      if (hit) begin
        priority if (mean > high_limit) begin
          res_status = ST_HOT;
        end else if (mean < low_limit) begin
          res_status = ST_COLD;
        end else begin
          res_status = ST_NORMAL;
        end
        res_room    = rec_q.room;
        res_mean    = mean;
        res_time    = time_q;
        res_held    = fill_q;
        ent_we      = cmd.finish;
        ent_wd.fill = fill_q;
        ent_wd.head = head_q;
        ent_wd.mean = mean;
        ent_wd.stamp = time_q;
      end else begin
        res_status = ST_UNKNOWN;
      end
    end else begin
      priority if (hit) begin
        res_status = ST_DUPLICATE;
        res_room   = rec_q.room;
        res_mean   = rec_q.mean;
        res_time   = rec_q.stamp;
        res_held   = rec_q.fill;
      end else if (used == USED_MAX) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_REGISTERED;
        res_room   = room_q;
        ent_we     = cmd.finish;
        ent_wa     = used[IDX_W-1:0];
        ent_wd     = '{id: id_q, room: room_q, fill: '0, head: '0, mean: '0, stamp: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.finish && kind_q == KIND_REGISTER && !hit && used != USED_MAX) begin
      used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {1'b0, res_held, res_time, res_mean, res_room, id_q, res_status};
    end
  end

  assign sts.scan_done = scan_done;
  assign sts.hit       = hit;
  assign sts.is_meas   = (kind_q == KIND_MEASURE);
  assign sts.sum_done  = sum_done;
  assign sts.div_done  = (div_cnt == '0);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

FILE: hw/rtl/sensor_moving_average_alarm_core.sv
// ----------------------------------------------------------------------------
// sensor_moving_average_alarm_core
// Moving-average temperature alarm over a table of registered sensors.
//
// Words enter on the s_axis channel; tuser selects a sensor registration
// (0) or a measurement (1). Each word gives exactly one result word on the
// m_axis channel. The limits are written through cfg_we/cfg_index/cfg_data
// while the block is idle; the user is bound to this, and the block itself
// does not enforce it. One word is handled at a time. The table search
// reads one entry per cycle from the table memory until the sensor is
// found, a measurement of a known sensor then reads the samples held (one
// window read per cycle), and a twenty-step serial divider forms the mean.
// The result sits in an output register: the next word is accepted while it
// waits, and a stalled receiver only holds the following result back.
// Reset empties the sensor table and restores the default limits of 20.0
// and 10.0 degrees, with no clearing pass.
// ----------------------------------------------------------------------------
module sensor_moving_average_alarm_core #(
  parameter int WINDOW      = 5,
  parameter int MAX_SENSORS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sensor [15:0], room_number [31:16], sample_value [47:32],
  // sample_time [79:48]
  input  logic [smaa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [2:0], echo_sensor [18:3], sensor_room [34:19],
  // window_mean [50:35], last_update [82:51], samples_held [86:83]
  output logic [smaa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [15:0]                     cfg_data
);
  import smaa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smaa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smaa_dp #(
    .WINDOW      (WINDOW),
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_kind   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sensor moving-average alarm core against a built-in predictor.
// Directed registrations and measurements cover the table edges and window
// wrap, then random traffic runs in phases with different limits, idle
// patterns on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import smaa_pkg::*;

  localparam int WIN       = 5;
  localparam int SLOTS     = 64;
  localparam int CYCLE_CAP = 1000000;

  typedef struct packed {
    logic [3:0]         held;
    logic [31:0]        stamp;
    logic signed [15:0] mean;
    logic [15:0]        room;
    logic [15:0]        sensor;
    logic [2:0]         status;
  } alarm_t;

  class alarm_scoreboard;
    logic [15:0]        id_of   [SLOTS];
    logic [15:0]        room_of [SLOTS];
    logic signed [15:0] win_of  [SLOTS][WIN];
    int                 fill_of [SLOTS];
    int                 head_of [SLOTS];
    logic signed [15:0] mean_of [SLOTS];
    logic [31:0]        stamp_of[SLOTS];
    int                 used;
    logic signed [15:0] hi_lim;
    logic signed [15:0] lo_lim;
    alarm_t             expected_q[$];
    int                 mismatches;

    function new();
      used = 0;
      hi_lim = 16'sd5120;
      lo_lim = 16'sd2560;
      mismatches = 0;
    endfunction

    function void set_limits(logic signed [15:0] hi, logic signed [15:0] lo);
      hi_lim = hi;
      lo_lim = lo;
    endfunction

    function void note_word(logic kind, logic [15:0] id, logic [15:0] room,
                            logic signed [15:0] val, logic [31:0] t);
      int     slot;
      int     sum;
      int     m;
      alarm_t r;
      slot = -1;
      for (int i = 0; i < used; i++) begin
        if (slot < 0 && id_of[i] == id) slot = i;
      end
      r = '0;
      r.sensor = id;
      if (kind == KIND_REGISTER) begin
        if (slot >= 0) begin
          r.status = ST_DUPLICATE;
          r.room = room_of[slot];
          r.mean = mean_of[slot];
          r.stamp = stamp_of[slot];
          r.held = 4'(fill_of[slot]);
        end else if (used >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          id_of[used] = id;
          room_of[used] = room;
          fill_of[used] = 0;
          head_of[used] = 0;
          mean_of[used] = '0;
          stamp_of[used] = '0;
          used++;
          r.status = ST_REGISTERED;
          r.room = room;
        end
      end else if (slot < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        stamp_of[slot] = t;
        win_of[slot][head_of[slot]] = val;
        head_of[slot] = (head_of[slot] + 1) % WIN;
        if (fill_of[slot] < WIN) fill_of[slot]++;
        sum = 0;
        for (int i = 0; i < fill_of[slot]; i++) sum += win_of[slot][i];
        m = sum / fill_of[slot];
        mean_of[slot] = 16'(m);
        if (m > hi_lim) r.status = ST_HOT;
        else if (m < lo_lim) r.status = ST_COLD;
        else r.status = ST_NORMAL;
        r.room = room_of[slot];
        r.mean = 16'(m);
        r.stamp = t;
        r.held = 4'(fill_of[slot]);
      end
      expected_q.push_back(r);
    endfunction

    function void check_word(alarm_t got);
      alarm_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.sensor !== exp.sensor ||
          got.room !== exp.room || got.mean !== exp.mean ||
          got.stamp !== exp.stamp || got.held !== exp.held) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: status %0d/%0d sensor %h/%h room %h/%h",
                    " mean %0d/%0d stamp %h/%h held %0d/%0d"},
                   exp.status, got.status, exp.sensor, got.sensor, exp.room, got.room,
                   exp.mean, got.mean, exp.stamp, got.stamp, exp.held, got.held);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [15:0]           cfg_data;

  alarm_scoreboard sb;
  int              send_idle;
  int              recv_idle;
  bit              recv_hold;
  int              cycles;
  logic [15:0]     id_pool[80];

  sensor_moving_average_alarm_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[sensor_moving_average_alarm_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(alarm_t'(m_axis_tdata[86:0]));
  end

  task automatic send_word(logic kind, logic [15:0] id, logic [15:0] room,
                           logic [15:0] val, logic [31:0] t);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {t, val, room, id};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(kind, id, room, val, t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_limits(logic [15:0] hi, logic [15:0] lo);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_HIGH_LIMIT;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= CFG_LOW_LIMIT;
    cfg_data <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(hi, lo);
  endtask

  task automatic random_word();
    logic        kind;
    logic [15:0] id;
    logic [15:0] val;
    kind = ($urandom_range(99) < 40) ? KIND_REGISTER : KIND_MEASURE;
    id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(79)] : 16'($urandom);
    case ($urandom_range(3))
      0: val = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1: val = 16'($urandom);
      default: val = 16'($urandom_range(7000));
    endcase
    send_word(kind, id, 16'($urandom), val, $urandom);
  endtask

  initial begin
    logic [15:0] lim_hi[4];
    logic [15:0] lim_lo[4];
    lim_hi = '{16'h7FFF, 16'h8000, 16'd3000, 16'h7FFF};
    lim_lo = '{16'h8000, 16'h7FFF, 16'd1000, 16'h8000};
    sb = new();
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    recv_hold = 1'b0;
    send_idle = 31;
    recv_idle = 46;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(KIND_MEASURE, 16'h1234, 16'h0, 16'h0, 32'h0);
    send_word(KIND_REGISTER, 16'h0000, 16'h0000, 16'h0, 32'h0);
    send_word(KIND_REGISTER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_word(KIND_REGISTER, 16'h0000, 16'h5555, 16'h0, 32'h0);
    send_word(KIND_MEASURE, 16'h0000, 16'hAAAA, 16'h7FFF, 32'h0);
    for (int i = 0; i < 6; i++)
      send_word(KIND_MEASURE, 16'h0000, 16'h0, 16'h8000, 32'hFFFFFFFF);
    send_word(KIND_REGISTER, 16'h0000, 16'h0, 16'h0, 32'h0);
    send_word(KIND_MEASURE, 16'hFFFF, 16'h0, 16'h0A00, 32'h1);
    send_word(KIND_MEASURE, 16'hFFFF, 16'h0, 16'h1400, 32'h2);
    send_word(KIND_MEASURE, 16'hFFFF, 16'h0, 16'h1401, 32'h3);
    send_word(KIND_MEASURE, 16'hFFFF, 16'h0, 16'hFFFF, 32'h4);
    send_word(KIND_MEASURE, 16'hFFFF, 16'h0, 16'h0000, 32'h5);

    for (int p = 0; p < 4; p++) begin
      write_limits(lim_hi[p], lim_lo[p]);
      send_idle = (p == 0) ? 31 : (p == 1) ? 46 : 0;
      recv_idle = (p == 0) ? 46 : (p == 1) ? 31 : 0;
      for (int n = 0; n < 100; n++) begin
        if (p == 2 && n == 20) begin
          fork
            begin
              recv_hold = 1'b1;
              repeat (400) @(posedge clk);
              recv_hold = 1'b0;
            end
          join_none
        end
        random_word();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[sensor_moving_average_alarm_core] OK");
    end else begin
      $display("[sensor_moving_average_alarm_core] ERROR");
    end
    $finish;
  end

endmodule
